// ===== hw/rtl/pca_pkg.sv =====
// Package for the clamped PID controller with angle-wrapped error.
// Holds register indexes, datapath command types and the saturate/clamp helpers.
// No dependencies.
package pca_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OPND_W  = 33;
  localparam int unsigned PROD_W  = 2 * OPND_W;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned CLAMP_W = 35;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE  = 3'd6;

  localparam logic signed [DATA_W-1:0] RST_OUT_UPPER = 32'sd6553600;
  localparam logic signed [DATA_W-1:0] RST_OUT_LOWER = -32'sd6553600;
  localparam logic [STEP_W-1:0]        RST_TIME_STEP = 16'd655;
  localparam logic [STEP_W-1:0]        RST_STEP_RATE = 16'd100;

  localparam logic signed [SUM_W-1:0] HALF_TURN = 34'sd11796480;
  localparam logic signed [SUM_W-1:0] FULL_TURN = 34'sd23592960;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_STEP,
    MUL_DIFF_RATE,
    MUL_PROP,
    MUL_INTEG,
    MUL_DERIV
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     fold;
    mul_sel_t mul_sel;
    logic     acc_upd;
    logic     der_upd;
    logic     sum_init;
    logic     sum_add;
    logic     out_load;
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_bounds(
    input logic signed [CLAMP_W-1:0] v,
    input logic signed [DATA_W-1:0]  up,
    input logic signed [DATA_W-1:0]  lo
  );
    logic signed [CLAMP_W-1:0] up_x;
    logic signed [CLAMP_W-1:0] lo_x;
    logic signed [DATA_W-1:0]  r;
    up_x = {{(CLAMP_W-DATA_W){up[DATA_W-1]}}, up};
    lo_x = {{(CLAMP_W-DATA_W){lo[DATA_W-1]}}, lo};
    if (v > up_x) begin
      r = up;
    end else if (v < lo_x) begin
      r = lo;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pca_in_if.sv =====
// Input channel: one control tick with setpoint and measurement.
// Uses pca_pkg for field widths.
interface pca_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pca_pkg::DATA_W-1:0]   setpoint;
  logic signed [pca_pkg::DATA_W-1:0]   measurement;

  modport source(output valid, output setpoint, output measurement, input ready);
  modport sink(input valid, input setpoint, input measurement, output ready);
endinterface

// ===== hw/rtl/pca_out_if.sv =====
// Result channel: clamped drive and the integral after the tick.
// Uses pca_pkg for field widths.
interface pca_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pca_pkg::DATA_W-1:0]   drive;
  logic signed [pca_pkg::DATA_W-1:0]   integral_term;

  modport source(output valid, output drive, output integral_term, input ready);
  modport sink(input valid, input drive, input integral_term, output ready);
endinterface

// ===== hw/rtl/pca_ctrl.sv =====
// Sequencer for the PID datapath: steps one tick through the shared multiplier.
// Uses pca_pkg for the command struct.
module pca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pca_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MULI,
    S_ACC,
    S_DER,
    S_PROP,
    S_INTG,
    S_DRVG,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = pca_pkg::MUL_NONE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.fold  = 1'b1;
        state_nxt = S_MULI;
      end
      S_MULI: begin
        cmd.mul_sel = pca_pkg::MUL_ERR_STEP;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_upd = 1'b1;
        cmd.mul_sel = pca_pkg::MUL_DIFF_RATE;
        state_nxt   = S_DER;
      end
      S_DER: begin
        cmd.der_upd = 1'b1;
        cmd.mul_sel = pca_pkg::MUL_PROP;
        state_nxt   = S_PROP;
      end
      S_PROP: begin
        cmd.sum_init = 1'b1;
        cmd.mul_sel  = pca_pkg::MUL_INTEG;
        state_nxt    = S_INTG;
      end
      S_INTG: begin
        cmd.sum_add = 1'b1;
        cmd.mul_sel = pca_pkg::MUL_DERIV;
        state_nxt   = S_DRVG;
      end
      S_DRVG: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_tick_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##8 (state_r == S_OUT))
    else $error("tick did not reach output step in eight cycles");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a transaction is pending");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

// ===== hw/rtl/pca_dp.sv =====
// Datapath for the PID controller: config registers, state, shared multiplier.
// Uses pca_pkg for widths, register indexes, commands and helpers.
module pca_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pca_pkg::dp_cmd_t                    cmd,
  input  logic                                cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pca_pkg::DATA_W-1:0]          cfg_wdata,
  input  logic signed [pca_pkg::DATA_W-1:0]   setpoint,
  input  logic signed [pca_pkg::DATA_W-1:0]   measurement,
  output logic signed [pca_pkg::DATA_W-1:0]   drive,
  output logic signed [pca_pkg::DATA_W-1:0]   integral_term
);

  localparam int unsigned DW = pca_pkg::DATA_W;
  localparam int unsigned SW = pca_pkg::STEP_W;
  localparam int unsigned OW = pca_pkg::OPND_W;
  localparam int unsigned PW = pca_pkg::PROD_W;
  localparam int unsigned UW = pca_pkg::SUM_W;
  localparam int unsigned CW = pca_pkg::CLAMP_W;
  localparam int unsigned FW = pca_pkg::FRAC_W;

  logic signed [DW-1:0] prop_gain_r, integ_gain_r, deriv_gain_r, out_upper_r, out_lower_r;
  logic [SW-1:0]        time_step_r, step_rate_r;
  logic signed [DW-1:0] integ_r, last_r;

  logic signed [DW:0]   diff_r;
  logic signed [DW-1:0] e_r, d_r, drive_r, integ_out_r;
  logic signed [PW-1:0] prod_r;
  logic signed [UW-1:0] sum_r;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_nxt;
  logic signed [UW-1:0] diff_x, fold_v;
  logic signed [DW-1:0] e_nxt, acc_nxt, term, d_nxt;
  logic signed [OW-1:0] inc;
  logic signed [CW-1:0] acc_sum;

  always_comb begin
    diff_x = {diff_r[DW], diff_r};
    if (diff_x < -pca_pkg::HALF_TURN) begin
      fold_v = diff_x + pca_pkg::FULL_TURN;
    end else if (diff_x > pca_pkg::HALF_TURN) begin
      fold_v = diff_x - pca_pkg::FULL_TURN;
    end else begin
      fold_v = diff_x;
    end
    e_nxt = pca_pkg::sat32({{(PW-UW){fold_v[UW-1]}}, fold_v});
  end

  always_comb begin
    case (cmd.mul_sel)
      pca_pkg::MUL_ERR_STEP: begin
        mul_a = {e_r[DW-1], e_r};
        mul_b = {{(OW-SW){1'b0}}, time_step_r};
      end
      pca_pkg::MUL_DIFF_RATE: begin
        mul_a = {e_r[DW-1], e_r} - {last_r[DW-1], last_r};
        mul_b = {{(OW-SW){1'b0}}, step_rate_r};
      end
      pca_pkg::MUL_PROP: begin
        mul_a = {e_r[DW-1], e_r};
        mul_b = {prop_gain_r[DW-1], prop_gain_r};
      end
      pca_pkg::MUL_INTEG: begin
        mul_a = {integ_r[DW-1], integ_r};
        mul_b = {integ_gain_r[DW-1], integ_gain_r};
      end
      pca_pkg::MUL_DERIV: begin
        mul_a = {d_r[DW-1], d_r};
        mul_b = {deriv_gain_r[DW-1], deriv_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    inc     = prod_r[FW+OW-1:FW];
    acc_sum = {{(CW-DW){integ_r[DW-1]}}, integ_r} + {{(CW-OW){inc[OW-1]}}, inc};
    acc_nxt = pca_pkg::clamp_bounds(acc_sum, out_upper_r, out_lower_r);
    d_nxt   = pca_pkg::sat32(prod_r);
    term    = pca_pkg::sat32(prod_r >>> FW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      out_upper_r  <= pca_pkg::RST_OUT_UPPER;
      out_lower_r  <= pca_pkg::RST_OUT_LOWER;
      time_step_r  <= pca_pkg::RST_TIME_STEP;
      step_rate_r  <= pca_pkg::RST_STEP_RATE;
      integ_r      <= '0;
      last_r       <= '0;
    end else begin
      if (cmd.acc_upd) integ_r <= acc_nxt;
      if (cmd.der_upd) last_r <= e_r;
      if (cfg_we) begin
        case (cfg_index)
          pca_pkg::CFG_PROP_GAIN:  prop_gain_r <= cfg_wdata;
          pca_pkg::CFG_INTEG_GAIN: begin
            integ_gain_r <= cfg_wdata;
            integ_r      <= '0;
          end
          pca_pkg::CFG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
          pca_pkg::CFG_OUT_UPPER:  out_upper_r  <= cfg_wdata;
          pca_pkg::CFG_OUT_LOWER:  out_lower_r  <= cfg_wdata;
          pca_pkg::CFG_TIME_STEP:  time_step_r  <= cfg_wdata[SW-1:0];
          pca_pkg::CFG_STEP_RATE:  step_rate_r  <= cfg_wdata[SW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) diff_r <= {setpoint[DW-1], setpoint} - {measurement[DW-1], measurement};
    if (cmd.fold) e_r <= e_nxt;
    if (cmd.mul_sel != pca_pkg::MUL_NONE) prod_r <= prod_nxt;
    if (cmd.der_upd) d_r <= d_nxt;
    if (cmd.sum_init) sum_r <= {{(UW-DW){term[DW-1]}}, term};
    if (cmd.sum_add) sum_r <= sum_r + {{(UW-DW){term[DW-1]}}, term};
    if (cmd.out_load) begin
      drive_r     <= pca_pkg::clamp_bounds({{(CW-UW){sum_r[UW-1]}}, sum_r},
                                           out_upper_r, out_lower_r);
      integ_out_r <= integ_r;
    end
  end

  assign drive         = drive_r;
  assign integral_term = integ_out_r;

endmodule

// ===== hw/rtl/pid_clamped_angle_wrap.sv =====
// Clamped PID controller with angle-wrapped error and integral anti-windup.
// Each tick steps through the sequencer states in order before its result
// sits in the output register. The accepting step takes the difference and
// the next step wraps it. The multiply steps run products on a single shared
// 33x33 multiplier (integral step, derivative, three gains). A further step
// adds the last gain term, and the output step clamps and loads the result.
// The next tick is accepted on the following cycle, once the last is through.
// A result left waiting at the output stalls only the following tick, at its
// load step, and no new tick is taken until that tick can load. Writing the
// integral gain clears the integral; configure only while idle.
module pid_clamped_angle_wrap (
  input  logic                           clk,
  input  logic                           rst_n,
  pca_in_if.sink                         in_chan,
  pca_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pca_pkg::DATA_W-1:0]     cfg_wdata
);

  pca_pkg::dp_cmd_t cmd;

  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  pca_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .setpoint      (in_chan.setpoint),
    .measurement   (in_chan.measurement),
    .drive         (out_chan.drive),
    .integral_term (out_chan.integral_term)
  );

endmodule
